// ===== rtl/wts_pkg.sv =====
// Shared types, constants and register codes for the window trend statistics block.
package wts_pkg;

	localparam int DATA_W         = 24;
	localparam int POS_W          = 23;
	localparam int CFG_W          = 24;
	localparam int CFG_IDX_W      = 3;
	localparam int PERIOD_W       = 7;
	localparam int TEND_W         = 2;
	localparam int SWCNT_W        = 16;
	localparam int MUL_W          = 26;
	localparam int WINDOW_MAX_DEF = 64;

	localparam logic [POS_W-1:0] POS_MAX    = {POS_W{1'b1}};
	localparam logic [MUL_W-1:0] EVO_SCALE  = MUL_W'(25600);

	localparam logic [PERIOD_W-1:0]   PERIOD_RST = PERIOD_W'(20);
	localparam logic [POS_W-1:0]      RHIGH_RST  = POS_W'(128);
	localparam logic signed [DATA_W-1:0] EHIGH_RST = DATA_W'(1280);
	localparam logic [POS_W-1:0]      RLOW_RST   = POS_W'(77);
	localparam logic signed [DATA_W-1:0] ELOW_RST  = -DATA_W'(1280);

	localparam logic signed [TEND_W-1:0] TEND_NONE = 2'sb00;
	localparam logic signed [TEND_W-1:0] TEND_RISE = 2'sb01;
	localparam logic signed [TEND_W-1:0] TEND_FALL = 2'sb11;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PERIOD = 3'd0,
		REG_RHIGH  = 3'd1,
		REG_EHIGH  = 3'd2,
		REG_RLOW   = 3'd3,
		REG_ELOW   = 3'd4
	} cfg_reg_t;

	typedef enum logic [4:0] {
		S_IDLE, S_CHECK, S_P1, S_MDIV, S_MWAIT, S_MFIX, S_P2, S_VDIV, S_VWAIT,
		S_VFIX, S_SWAIT, S_SFIX, S_RDIV, S_RWAIT, S_RFIX, S_GHI, S_GLO, S_GCMP,
		S_ECHK, S_EMUL, S_EHI, S_ELO, S_ECMP, S_EDIV, S_EWAIT, S_EFIX, S_LOAD
	} ctrl_state_t;

	typedef enum logic [4:0] {
		OP_NONE, OP_PUSH, OP_PSTART, OP_P1, OP_MDIV, OP_MFIX, OP_P2, OP_VDIV,
		OP_VFIX, OP_SFIX, OP_RDIV, OP_RFIX, OP_GHI, OP_GLO, OP_GCMP, OP_EMUL,
		OP_EHI, OP_ELO, OP_ECMP, OP_EDIV, OP_EFIX, OP_LOAD
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic pass_done;
		logic div_done;
		logic sqrt_done;
		logic rise_nz;
		logic old_nz;
		logic out_free;
	} status_t;

endpackage

// ===== rtl/wts_div.sv =====
// Restoring divider, one quotient bit per cycle.
module wts_div #(
	parameter int N = 56,
	parameter int M = 24
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [N-1:0] dividend,
	input  logic [M-1:0] divisor,
	output logic [N-1:0] quo,
	output logic [M-1:0] rem,
	output logic         done
);
	localparam int CW = $clog2(N + 1);

	logic [N-1:0]  quo_q;
	logic [M-1:0]  rem_q;
	logic [M-1:0]  dvs_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [M:0]    sh;
	logic          take;

	assign sh   = {rem_q, quo_q[N-1]};
	assign take = sh >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(N);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= take ? M'(sh - {1'b0, dvs_q}) : M'(sh);
			quo_q <= {quo_q[N-2:0], take};
		end
	end

	assign quo  = quo_q;
	assign rem  = rem_q;
	assign done = done_q;
endmodule

// ===== rtl/wts_sqrt.sv =====
// Iterative integer square root, two radicand bits per cycle.
module wts_sqrt #(
	parameter int W = 56
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic [W-1:0]   radicand,
	output logic [W/2-1:0] root,
	output logic           done
);
	localparam int R  = W / 2;
	localparam int CW = $clog2(R + 1);

	logic [W-1:0]  v_q;
	logic [W-1:0]  res_q;
	logic [W-1:0]  bit_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [W:0]    trial;
	logic          take;

	assign trial = {1'b0, res_q} + {1'b0, bit_q};
	assign take  = {1'b0, v_q} >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(R);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			v_q   <= radicand;
			res_q <= '0;
			bit_q <= W'(1) << (W - 2);
		end else if (busy_q) begin
			if (take) begin
				v_q   <= W'({1'b0, v_q} - trial);
				res_q <= (res_q >> 1) + bit_q;
			end else begin
				res_q <= res_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

	assign root = res_q[R-1:0];
	assign done = done_q;
endmodule

// ===== rtl/wts_dp.sv =====
// Datapath: config registers, sample ring, accumulators, shared multiplier and result word.
module wts_dp #(
	parameter int WINDOW_MAX = wts_pkg::WINDOW_MAX_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_wr_en,
	input  logic [wts_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [wts_pkg::CFG_W-1:0]          cfg_data,
	input  logic signed [wts_pkg::DATA_W-1:0]  sample,
	input  wts_pkg::cmd_t                      cmd,
	output wts_pkg::status_t                   status,
	input  logic                               out_ready,
	output logic                               out_valid,
	output logic [wts_pkg::POS_W-1:0]          increase_avg,
	output logic signed [wts_pkg::DATA_W-1:0]  relative_evolution,
	output logic [wts_pkg::POS_W-1:0]          std_dev,
	output logic                               window_full,
	output logic                               evolution_valid,
	output logic signed [wts_pkg::TEND_W-1:0]  tendency,
	output logic                               switch_seen,
	output logic [wts_pkg::SWCNT_W-1:0]        switch_total
);
	import wts_pkg::*;

	localparam int CNT_W = $clog2(WINDOW_MAX + 1);
	localparam int AW    = $clog2(WINDOW_MAX);
	localparam int S_W   = DATA_W + CNT_W;
	localparam int T_W   = 2 * DATA_W + CNT_W;
	localparam int DIV_N = T_W;
	localparam int D_W   = (CNT_W > DATA_W) ? CNT_W : DATA_W;
	localparam int SQ_W  = T_W + (T_W % 2);
	localparam int SQ_R  = SQ_W / 2;
	localparam int P_W   = 2 * MUL_W;

	// configuration
	logic [PERIOD_W-1:0]      period_q;
	logic [POS_W-1:0]         rhigh_q, rlow_q;
	logic signed [DATA_W-1:0] ehigh_q, elow_q;

	// window ring
	logic signed [DATA_W-1:0] mem [WINDOW_MAX];
	logic [AW-1:0]            head_q, head_nxt, rd_addr;
	logic [CNT_W-1:0]         fill_q, p_q, idx_q;
	logic [AW:0]              h_ext, i_ext;

	// pass pipeline
	logic                     v_s1, first_s1, last_s1, v_s2, v_s3;
	logic signed [DATA_W-1:0] rd_data_s1;
	logic signed [DATA_W:0]   d_s2;
	logic                     issue;

	// accumulators and intermediates
	logic signed [S_W-1:0]    sum_q;
	logic [S_W-1:0]           rsum_q;
	logic [CNT_W-1:0]         rcnt_q;
	logic signed [DATA_W-1:0] prev_q, c_q, o_q, mean_q;
	logic [CNT_W-1:0]         rmd_q;
	logic [T_W-1:0]           tsum_q;
	logic signed [P_W-1:0]    num_q, mul_q;
	logic signed [MUL_W-1:0]  mul_a, mul_b;
	logic                     mul_en;
	logic                     g_gt_q, g_lt_q, r_gt_q, r_lt_q;
	logic signed [DATA_W:0]   diff1;
	logic signed [P_W-1:0]    rsum_s;

	// results
	logic [POS_W-1:0]         inc_q, std_q;
	logic signed [DATA_W-1:0] evo_q;
	logic                     evo_valid_q, seen_q, full_q;
	logic signed [TEND_W-1:0] tend_q, nt;
	logic [SWCNT_W-1:0]       swcnt_q;
	logic                     out_valid_q;

	// shared units
	logic                     div_start, div_done, sqrt_start, sqrt_done;
	logic [DIV_N-1:0]         div_dvd, div_quo;
	logic [D_W-1:0]           div_dvs, div_rem;
	logic [SQ_W-1:0]          sq_in;
	logic [SQ_R-1:0]          sq_root;

	logic [S_W-1:0]           sum_abs;
	logic signed [DATA_W:0]   o_ext, o_abs;
	logic signed [P_W-1:0]    num_abs;
	logic signed [DATA_W:0]   m25;
	logic [2*CNT_W-1:0]       pb, rr;
	logic [CNT_W-1:0]         b_rem;
	logic [DIV_N-1:0]         var_v;
	logic                     evo_neg;
	logic [DATA_W:0]          evo_mag;
	logic [CNT_W-1:0]         p_eff;

	dp_op_t op;
	assign op = cmd.op;

	always_comb begin
		if (period_q == '0) begin
			p_eff = CNT_W'(1);
		end else if (int'(period_q) > WINDOW_MAX) begin
			p_eff = CNT_W'(WINDOW_MAX);
		end else begin
			p_eff = CNT_W'(period_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q <= PERIOD_RST;
			rhigh_q  <= RHIGH_RST;
			ehigh_q  <= EHIGH_RST;
			rlow_q   <= RLOW_RST;
			elow_q   <= ELOW_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_PERIOD: period_q <= cfg_data[PERIOD_W-1:0];
				REG_RHIGH:  rhigh_q  <= cfg_data[POS_W-1:0];
				REG_EHIGH:  ehigh_q  <= cfg_data;
				REG_RLOW:   rlow_q   <= cfg_data[POS_W-1:0];
				REG_ELOW:   elow_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// ring addressing: entry i back from the newest
	assign head_nxt = (head_q == AW'(WINDOW_MAX - 1)) ? '0 : head_q + 1'b1;
	assign h_ext    = (AW+1)'(head_q);
	assign i_ext    = (AW+1)'(idx_q);
	assign rd_addr  = (h_ext >= i_ext) ? AW'(h_ext - i_ext)
	                                   : AW'(h_ext + (AW+1)'(WINDOW_MAX) - i_ext);
	assign issue    = (op == OP_P1 || op == OP_P2) && (idx_q < p_q);

	always_ff @(posedge clk) begin
		if (op == OP_PUSH) begin
			mem[head_nxt] <= sample;
		end
		rd_data_s1 <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			fill_q <= '0;
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			v_s3   <= 1'b0;
			idx_q  <= '0;
		end else begin
			v_s1 <= issue;
			v_s2 <= v_s1 && (op == OP_P2);
			v_s3 <= v_s2;
			if (op == OP_PUSH) begin
				head_q <= head_nxt;
				if (fill_q < CNT_W'(WINDOW_MAX)) begin
					fill_q <= fill_q + 1'b1;
				end
			end
			if (op == OP_PSTART || op == OP_MFIX) begin
				idx_q <= '0;
			end else if (issue) begin
				idx_q <= idx_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		first_s1 <= idx_q == '0;
		last_s1  <= idx_q == p_q - 1'b1;
		d_s2     <= DATA_W'(rd_data_s1) - (DATA_W+1)'(mean_q);
	end

	// shared multiplier, registered
	always_comb begin
		mul_a  = '0;
		mul_b  = '0;
		mul_en = 1'b1;
		case (op)
			OP_P2: begin
				mul_a = MUL_W'(d_s2);
				mul_b = MUL_W'(d_s2);
			end
			OP_GHI: begin
				mul_a = $signed(MUL_W'(rhigh_q));
				mul_b = $signed(MUL_W'(rcnt_q));
			end
			OP_GLO: begin
				mul_a = $signed(MUL_W'(rlow_q));
				mul_b = $signed(MUL_W'(rcnt_q));
			end
			OP_EMUL: begin
				mul_a = MUL_W'(diff1);
				mul_b = $signed(EVO_SCALE);
			end
			OP_EHI: begin
				mul_a = MUL_W'(ehigh_q);
				mul_b = MUL_W'(o_q);
			end
			OP_ELO: begin
				mul_a = MUL_W'(elow_q);
				mul_b = MUL_W'(o_q);
			end
			default: mul_en = 1'b0;
		endcase
	end

	assign diff1 = (DATA_W+1)'(c_q) - (DATA_W+1)'(o_q);

	always_ff @(posedge clk) begin
		if (mul_en) begin
			mul_q <= mul_a * mul_b;
		end
	end

	// divider and square root operands
	assign sum_abs = (sum_q < 0) ? S_W'(-sum_q) : S_W'(sum_q);
	assign o_ext   = (DATA_W+1)'(o_q);
	assign o_abs   = (o_ext < 0) ? -o_ext : o_ext;
	assign num_abs = (num_q < 0) ? -num_q : num_q;

	always_comb begin
		div_start = 1'b1;
		div_dvd   = '0;
		div_dvs   = '0;
		case (op)
			OP_MDIV: begin
				div_dvd = DIV_N'(sum_abs);
				div_dvs = D_W'(p_q);
			end
			OP_VDIV: begin
				div_dvd = DIV_N'(tsum_q);
				div_dvs = D_W'(p_q);
			end
			OP_RDIV: begin
				div_dvd = DIV_N'(rsum_q);
				div_dvs = D_W'(rcnt_q);
			end
			OP_EDIV: begin
				div_dvd = DIV_N'($unsigned(num_abs));
				div_dvs = D_W'($unsigned(o_abs));
			end
			default: div_start = 1'b0;
		endcase
	end

	wts_div #(.N(DIV_N), .M(D_W)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dvd),
		.divisor  (div_dvs),
		.quo      (div_quo),
		.rem      (div_rem),
		.done     (div_done)
	);

	assign b_rem      = CNT_W'(div_rem);
	assign pb         = (2*CNT_W)'(p_q) * (2*CNT_W)'(b_rem);
	assign rr         = (2*CNT_W)'(rmd_q) * (2*CNT_W)'(rmd_q);
	assign var_v      = (pb < rr && div_quo != '0) ? div_quo - 1'b1 : div_quo;
	assign sq_in      = SQ_W'(var_v);
	assign sqrt_start = op == OP_VFIX;

	wts_sqrt #(.W(SQ_W)) u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sqrt_start),
		.radicand (sq_in),
		.root     (sq_root),
		.done     (sqrt_done)
	);

	// floor of the mean from the magnitude quotient
	assign m25 = (sum_q < 0)
		? -$signed((DATA_W+1)'(div_quo)) - $signed((DATA_W+1)'(div_rem != '0))
		: $signed((DATA_W+1)'(div_quo));

	assign rsum_s  = $signed(P_W'(rsum_q));
	assign evo_neg = num_q[P_W-1] ^ o_q[DATA_W-1];
	assign evo_mag = (div_quo > DIV_N'(POS_MAX) + 1'b1) ? (DATA_W+1)'(POS_MAX) + 1'b1
	                                                     : (DATA_W+1)'(div_quo);

	always_comb begin
		if (g_gt_q && r_gt_q) begin
			nt = TEND_RISE;
		end else if (g_lt_q && r_lt_q) begin
			nt = TEND_FALL;
		end else begin
			nt = TEND_NONE;
		end
	end

	always_ff @(posedge clk) begin
		case (op)
			OP_PUSH: begin
				p_q         <= p_eff;
				sum_q       <= '0;
				rsum_q      <= '0;
				rcnt_q      <= '0;
				tsum_q      <= '0;
				inc_q       <= '0;
				evo_q       <= '0;
				std_q       <= '0;
				evo_valid_q <= 1'b0;
				seen_q      <= 1'b0;
			end
			OP_MFIX: begin
				mean_q <= DATA_W'(m25);
				if (sum_q >= 0) begin
					rmd_q <= b_rem;
				end else begin
					rmd_q <= (b_rem != '0) ? p_q - b_rem : '0;
				end
			end
			OP_SFIX: std_q <= (SQ_R'(sq_root) > SQ_R'(POS_MAX)) ? POS_MAX : POS_W'(sq_root);
			OP_RFIX: inc_q <= (div_quo > DIV_N'(POS_MAX)) ? POS_MAX : POS_W'(div_quo);
			OP_GLO:  g_gt_q <= (rcnt_q != '0) && (rsum_s > mul_q);
			OP_GCMP: g_lt_q <= (rcnt_q != '0) ? (rsum_s < mul_q) : (rlow_q != '0);
			OP_EHI:  num_q <= mul_q;
			OP_ELO:  r_gt_q <= (o_q > 0) ? (num_q > mul_q) : (num_q < mul_q);
			OP_ECMP: r_lt_q <= (o_q > 0) ? (num_q < mul_q) : (num_q > mul_q);
			OP_EFIX: begin
				evo_valid_q <= 1'b1;
				if (evo_neg) begin
					evo_q <= DATA_W'(-$signed(evo_mag));
				end else begin
					evo_q <= (evo_mag > (DATA_W+1)'(POS_MAX)) ? DATA_W'(POS_MAX)
					                                         : DATA_W'(evo_mag);
				end
				if (tend_q != TEND_NONE && nt != TEND_NONE && tend_q != nt) begin
					seen_q <= 1'b1;
				end
			end
			default: ;
		endcase

		// pass one: sum, rises, newest and oldest samples
		if (v_s1 && op == OP_P1) begin
			sum_q  <= sum_q + S_W'(rd_data_s1);
			prev_q <= rd_data_s1;
			if (first_s1) begin
				c_q <= rd_data_s1;
			end else if ((DATA_W+1)'(prev_q) - (DATA_W+1)'(rd_data_s1) > 0) begin
				rsum_q <= rsum_q + S_W'(DATA_W'(prev_q) - (DATA_W+1)'(rd_data_s1));
				rcnt_q <= rcnt_q + 1'b1;
			end
			if (last_s1) begin
				o_q <= rd_data_s1;
			end
		end

		// pass two: squared deviations
		if (v_s3) begin
			tsum_q <= tsum_q + T_W'($unsigned(mul_q));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tend_q  <= TEND_NONE;
			swcnt_q <= '0;
			full_q  <= 1'b0;
		end else begin
			if (op == OP_PSTART) begin
				full_q <= fill_q >= p_q;
			end
			if (op == OP_EFIX && nt != TEND_NONE) begin
				tend_q <= nt;
				if (tend_q != TEND_NONE && tend_q != nt && swcnt_q != '1) begin
					swcnt_q <= swcnt_q + 1'b1;
				end
			end
		end
	end

	// output word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (op == OP_LOAD) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (op == OP_LOAD) begin
			increase_avg       <= inc_q;
			relative_evolution <= evo_q;
			std_dev            <= std_q;
			window_full        <= full_q;
			evolution_valid    <= evo_valid_q;
			tendency           <= tend_q;
			switch_seen        <= seen_q;
			switch_total       <= swcnt_q;
		end
	end

	assign out_valid = out_valid_q;

	always_comb begin
		status.full      = fill_q >= p_q;
		status.pass_done = (idx_q == p_q) && !v_s1 && !v_s2 && !v_s3;
		status.div_done  = div_done;
		status.sqrt_done = sqrt_done;
		status.rise_nz   = rcnt_q != '0;
		status.old_nz    = o_q != '0;
		status.out_free  = !out_valid_q || out_ready;
	end
endmodule

// ===== rtl/wts_ctrl.sv =====
// Sequencer: steps the datapath through both passes, the divisions and the square root.
module wts_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  wts_pkg::status_t status,
	output wts_pkg::cmd_t    cmd
);
	import wts_pkg::*;

	ctrl_state_t state_q, state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			S_IDLE:  if (in_valid) state_nxt = S_CHECK;
			S_CHECK: state_nxt = status.full ? S_P1 : S_LOAD;
			S_P1:    if (status.pass_done) state_nxt = S_MDIV;
			S_MDIV:  state_nxt = S_MWAIT;
			S_MWAIT: if (status.div_done) state_nxt = S_MFIX;
			S_MFIX:  state_nxt = S_P2;
			S_P2:    if (status.pass_done) state_nxt = S_VDIV;
			S_VDIV:  state_nxt = S_VWAIT;
			S_VWAIT: if (status.div_done) state_nxt = S_VFIX;
			S_VFIX:  state_nxt = S_SWAIT;
			S_SWAIT: if (status.sqrt_done) state_nxt = S_SFIX;
			S_SFIX:  state_nxt = S_RDIV;
			S_RDIV:  state_nxt = status.rise_nz ? S_RWAIT : S_GHI;
			S_RWAIT: if (status.div_done) state_nxt = S_RFIX;
			S_RFIX:  state_nxt = S_GHI;
			S_GHI:   state_nxt = S_GLO;
			S_GLO:   state_nxt = S_GCMP;
			S_GCMP:  state_nxt = S_ECHK;
			S_ECHK:  state_nxt = status.old_nz ? S_EMUL : S_LOAD;
			S_EMUL:  state_nxt = S_EHI;
			S_EHI:   state_nxt = S_ELO;
			S_ELO:   state_nxt = S_ECMP;
			S_ECMP:  state_nxt = S_EDIV;
			S_EDIV:  state_nxt = S_EWAIT;
			S_EWAIT: if (status.div_done) state_nxt = S_EFIX;
			S_EFIX:  state_nxt = S_LOAD;
			S_LOAD:  if (status.out_free) state_nxt = S_IDLE;
			default: state_nxt = S_IDLE;
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		cmd.op   = OP_NONE;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) cmd.op = OP_PUSH;
			end
			S_CHECK: cmd.op = OP_PSTART;
			S_P1:    cmd.op = OP_P1;
			S_MDIV:  cmd.op = OP_MDIV;
			S_MFIX:  cmd.op = OP_MFIX;
			S_P2:    cmd.op = OP_P2;
			S_VDIV:  cmd.op = OP_VDIV;
			S_VFIX:  cmd.op = OP_VFIX;
			S_SFIX:  cmd.op = OP_SFIX;
			S_RDIV:  if (status.rise_nz) cmd.op = OP_RDIV;
			S_RFIX:  cmd.op = OP_RFIX;
			S_GHI:   cmd.op = OP_GHI;
			S_GLO:   cmd.op = OP_GLO;
			S_GCMP:  cmd.op = OP_GCMP;
			S_EMUL:  cmd.op = OP_EMUL;
			S_EHI:   cmd.op = OP_EHI;
			S_ELO:   cmd.op = OP_ELO;
			S_ECMP:  cmd.op = OP_ECMP;
			S_EDIV:  cmd.op = OP_EDIV;
			S_EFIX:  cmd.op = OP_EFIX;
			S_LOAD:  if (status.out_free) cmd.op = OP_LOAD;
			default: cmd.op = OP_NONE;
		endcase
	end
endmodule

// ===== rtl/window_trend_statistics.sv =====
// Moving-window trend statistics: rise mean, percent change, std deviation and tendency.
//
// Input channel (in_valid/in_ready) takes one signed Q16.8 sample per word; every
// accepted word gives exactly one result word on the output channel
// (out_valid/out_ready). Samples go into a ring of WINDOW_MAX entries.
// Per word, with P the effective period: one read pass for sum, rises and the
// end samples, the mean by division, a second pass for squared deviations,
// the variance by division, a 28-step square root, then rise mean and percent
// change by division. The shared restoring divider works one bit per cycle over
// a dividend of 2*24 + log2 width bits, 55 at the default size. While the window
// is not yet full a word skips the passes, divisions and square root.
// in_ready is high only while no word is in progress. The result sits in an
// output register, so a new sample is taken while the previous result is still
// waiting; if the receiver stalls, the finished next result waits inside until
// the output register frees.
// Reset clears the fill count, tendency, switch counter and config to defaults.
// Config writes (cfg_wr_en/cfg_index/cfg_data) must only be made between words.
module window_trend_statistics #(
	parameter int WINDOW_MAX = wts_pkg::WINDOW_MAX_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_wr_en,
	input  logic [wts_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [wts_pkg::CFG_W-1:0]          cfg_data,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic signed [wts_pkg::DATA_W-1:0]  sample,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [wts_pkg::POS_W-1:0]          increase_avg,
	output logic signed [wts_pkg::DATA_W-1:0]  relative_evolution,
	output logic [wts_pkg::POS_W-1:0]          std_dev,
	output logic                               window_full,
	output logic                               evolution_valid,
	output logic signed [wts_pkg::TEND_W-1:0]  tendency,
	output logic                               switch_seen,
	output logic [wts_pkg::SWCNT_W-1:0]        switch_total
);
	import wts_pkg::*;

	cmd_t    cmd;
	status_t status;

	wts_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	wts_dp #(.WINDOW_MAX(WINDOW_MAX)) u_dp (
		.clk                (clk),
		.arst_n             (arst_n),
		.cfg_wr_en          (cfg_wr_en),
		.cfg_index          (cfg_index),
		.cfg_data           (cfg_data),
		.sample             (sample),
		.cmd                (cmd),
		.status             (status),
		.out_ready          (out_ready),
		.out_valid          (out_valid),
		.increase_avg       (increase_avg),
		.relative_evolution (relative_evolution),
		.std_dev            (std_dev),
		.window_full        (window_full),
		.evolution_valid    (evolution_valid),
		.tendency           (tendency),
		.switch_seen        (switch_seen),
		.switch_total       (switch_total)
	);

	// one word in flight: no second accept straight after the first
	a_single_word: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("second word accepted while one is in progress");

	// a result only appears once its word has been worked on
	a_no_early_result: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !$rose(out_valid))
		else $error("result raised in the cycle after accept");

	a_evo_needs_full: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (!evolution_valid || window_full))
		else $error("percent change valid without a full window");

	a_switch_counted: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && switch_seen) |-> (switch_total != '0 && tendency != TEND_NONE))
		else $error("switch flagged but not counted");
endmodule
